@@ rtl/core/tgft_pkg.sv @@
// Shared types and constants for the trot gait foot trajectory block.
// Stream word layouts and the sideband carried along the phase pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgft_pkg;

  localparam int unsigned PhaseW  = 16;
  localparam int unsigned AmpW    = 16;
  localparam int unsigned DirW    = 8;
  localparam int unsigned XW      = 24;
  localparam int unsigned ZW      = 16;
  localparam int unsigned NumLegs = 4;

  localparam int unsigned InDataW  = PhaseW + 2 * AmpW + NumLegs * DirW;  // 80
  localparam int unsigned OutDataW = NumLegs * (XW + ZW);                 // 160

  // Bit offsets inside the slave-side word
  localparam int unsigned StrideLo = PhaseW;
  localparam int unsigned LiftLo   = PhaseW + AmpW;
  localparam int unsigned DirLo    = PhaseW + 2 * AmpW;

  // Bit offsets inside the master-side word
  localparam int unsigned ZLo = NumLegs * XW;

  // Fields that ride along while the phase is turned into curve factors
  typedef struct packed {
    logic [NumLegs-1:0][DirW-1:0] dir;
    logic [AmpW-1:0]              lift;
    logic [AmpW-1:0]              stride;
  } tgft_side_t;

endpackage

`default_nettype wire

@@ rtl/core/trot_gait_foot_trajectory_top.sv @@
// Top level of the trot gait foot trajectory block: five-stage stream pipeline.
// Instantiates tgft_factor for the phase stages; depends on tgft_pkg.
//
// Usage:
//   Slave channel s_axis_* takes one word per gait sample: phase (Q0.16), stride,
//   lift height and four leg direction factors. Master channel m_axis_* returns one
//   word per sample with forward (x) and vertical (z) targets for all four legs.
//   Legs 1 and 3 swing in the first half of the cycle, legs 2 and 4 in the second;
//   the supporting pair reports z = 0.
//   Pipeline: five register stages (square, cube, polynomial, amplitude multiply,
//   direction multiply). Throughput: one word per cycle while m_axis_tready is high;
//   every stage holds a valid bit and accepts when it is empty or its successor
//   moves, so bubbles are squeezed out during a stall.
//   When m_axis_tready is low the output word holds and the pipeline fills up to five
//   words before s_axis_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module trot_gait_foot_trajectory_top import tgft_pkg::*; #(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // phase[15:0], stride[31:16], lift_height[47:32], dir_leg1[55:48],
  // dir_leg2[63:56], dir_leg3[71:64], dir_leg4[79:72]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // x_leg1[23:0], x_leg2[47:24], x_leg3[71:48], x_leg4[95:72],
  // z_leg1[111:96], z_leg2[127:112], z_leg3[143:128], z_leg4[159:144]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned P  = PHASE_BITS;
  localparam int unsigned PW = AmpW + P + 2;

  tgft_side_t side_in, side_c;
  logic       vc, ready_d, ready_e, sec_c;
  logic [P:0] fx_c, fz_c, fs_c;

  assign side_in.stride = s_axis_tdata[StrideLo +: AmpW];
  assign side_in.lift   = s_axis_tdata[LiftLo +: AmpW];
  assign side_in.dir    = s_axis_tdata[DirLo +: NumLegs * DirW];

  tgft_factor #(
    .PHASE_BITS(PHASE_BITS)
  ) u_factor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .phase_i    (s_axis_tdata[PhaseW-1:0]),
    .side_i     (side_in),
    .out_valid_o(vc),
    .out_ready_i(ready_d),
    .out_side_o (side_c),
    .second_o   (sec_c),
    .fsw_x_o    (fx_c),
    .fsw_z_o    (fz_c),
    .fsup_o     (fs_c)
  );

  logic vd_q, ve_q;

  assign ready_e = !ve_q || m_axis_tready;
  assign ready_d = !vd_q || ready_e;
  assign m_axis_tvalid = ve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (ready_d) vd_q <= vc;
      if (ready_e) ve_q <= vd_q;
    end
  end

  // Stage D: scale curve factors by amplitude, floor shift
  logic signed [PW-1:0] px, pz, ps;

  assign px = $signed(side_c.stride) * $signed({1'b0, fx_c});
  assign pz = $signed(side_c.lift) * $signed({1'b0, fz_c});
  assign ps = $signed(side_c.stride) * $signed({1'b0, fs_c});

  logic [AmpW-1:0]              swx_q, swz_q, supx_q;
  logic                         secd_q;
  logic [NumLegs-1:0][DirW-1:0] dird_q;

  always_ff @(posedge clk_i) begin
    if (ready_d && vc) begin
      swx_q  <= px[P+AmpW-1:P];
      swz_q  <= pz[P+AmpW-1:P];
      supx_q <= ps[P+AmpW-1:P];
      secd_q <= sec_c;
      dird_q <= side_c.dir;
    end
  end

  // Stage E: pick swing or support per leg, apply direction
  logic [OutDataW-1:0] data_d;
  logic [OutDataW-1:0] data_q;

  always_comb begin
    logic                 swinging;
    logic [AmpW-1:0]      sel;
    logic signed [XW-1:0] prod;
    data_d = '0;
    for (int k = 0; k < NumLegs; k++) begin
      swinging = (k % 2 == 1) == secd_q;
      sel = swinging ? swx_q : supx_q;
      // full 24-bit product: most negative stride times most negative direction
      prod = $signed(sel) * $signed(dird_q[k]);
      data_d[k*XW +: XW] = prod;
      data_d[ZLo + k*ZW +: ZW] = swinging ? swz_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_e && vd_q) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tdata = data_q;

endmodule

`default_nettype wire

@@ rtl/core/tgft_factor.sv @@
// Three-stage pipeline from gait phase to swing and support curve factors.
// Stage A squares the local phase, stage B cubes it, stage C sums and clamps.
// Depends on tgft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgft_factor import tgft_pkg::*; #(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PhaseW-1:0]     phase_i,
  input  tgft_side_t            side_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tgft_side_t            out_side_o,
  output logic                  second_o,
  output logic [PHASE_BITS:0]   fsw_x_o,
  output logic [PHASE_BITS:0]   fsw_z_o,
  output logic [PHASE_BITS:0]   fsup_o
);

  localparam int unsigned P  = PHASE_BITS;
  localparam int unsigned SW = P + 7;
  localparam logic [P:0] OneQ = {1'b1, {P{1'b0}}};

  function automatic logic [P:0] clamp_f(input logic signed [SW-1:0] v);
    logic [P:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(SW'(OneQ))) begin
      r = OneQ;
    end else begin
      r = v[P:0];
    end
    return r;
  endfunction

  logic ready_a, ready_b, ready_c;
  logic va_q, vb_q, vc_q;

  assign ready_c    = !vc_q || out_ready_i;
  assign ready_b    = !vb_q || ready_c;
  assign ready_a    = !va_q || ready_b;
  assign in_ready_o = ready_a;
  assign out_valid_o = vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= in_valid_i;
      if (ready_b) vb_q <= va_q;
      if (ready_c) vc_q <= vb_q;
    end
  end

  // Stage A: local phase and its square
  logic [P+PhaseW-1:0] ph_ext;
  logic [P-1:0]        ph;
  logic [P-1:0]        u_in;
  logic [2*P-1:0]      sq_in;

  assign ph_ext = {{P{1'b0}}, phase_i};
  assign ph     = ph_ext[P-1:0];
  assign u_in   = {ph[P-2:0], 1'b0};
  assign sq_in  = u_in * u_in;

  logic [P-1:0] ua_q, u2a_q;
  logic         seca_q;
  tgft_side_t   sidea_q;

  always_ff @(posedge clk_i) begin
    if (ready_a && in_valid_i) begin
      ua_q    <= u_in;
      u2a_q   <= sq_in[2*P-1:P];
      seca_q  <= ph[P-1];
      sidea_q <= side_i;
    end
  end

  // Stage B: cube
  logic [2*P-1:0] cube;
  assign cube = u2a_q * ua_q;

  logic [P-1:0] ub_q, u2b_q, u3b_q;
  logic         secb_q;
  tgft_side_t   sideb_q;

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      ub_q    <= ua_q;
      u2b_q   <= u2a_q;
      u3b_q   <= cube[2*P-1:P];
      secb_q  <= seca_q;
      sideb_q <= sidea_q;
    end
  end

  // Stage C: polynomials, clamp to [0, 1.0]
  logic signed [SW-1:0] t1, t2, t3;
  logic signed [SW-1:0] poly_x, poly_z_lo, poly_z_hi;
  logic [P:0]           fx_d, fz_d, fs_d;

  assign t1 = $signed(SW'(ub_q));
  assign t2 = $signed(SW'(u2b_q));
  assign t3 = $signed(SW'(u3b_q));

  assign poly_x    = $signed(SW'(OneQ)) - (t3 <<< 4) + (t2 <<< 4) + (t2 <<< 3)
                     - (t1 <<< 3) - t1;
  assign poly_z_lo = (t2 <<< 3) + (t2 <<< 2) - (t3 <<< 4);
  assign poly_z_hi = (t1 <<< 2) - (t2 <<< 2);

  always_comb begin
    if (ub_q[P-1:P-2] == 2'b00) begin
      fx_d = '0;
    end else if (ub_q[P-1:P-2] == 2'b11) begin
      fx_d = OneQ;
    end else begin
      fx_d = clamp_f(poly_x);
    end
    fz_d = ub_q[P-1] ? clamp_f(poly_z_hi) : clamp_f(poly_z_lo);
    fs_d = OneQ - {1'b0, ub_q};
  end

  always_ff @(posedge clk_i) begin
    if (ready_c && vb_q) begin
      fsw_x_o    <= fx_d;
      fsw_z_o    <= fz_d;
      fsup_o     <= fs_d;
      second_o   <= secb_q;
      out_side_o <= sideb_q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tgft_checker.sv @@
// Port-level checks for the trot gait foot trajectory block, bound to the top level.
// Depends on tgft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgft_checker import tgft_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // A ready sink drains every stage, so the input side must be open
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled with ready sink");

  // One diagonal pair always supports and reports zero height
  a_support_pair_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[ZLo +: ZW] == '0 && m_axis_tdata[ZLo + 2*ZW +: ZW] == '0) ||
      (m_axis_tdata[ZLo + ZW +: ZW] == '0 && m_axis_tdata[ZLo + 3*ZW +: ZW] == '0))
    else $error("no supporting pair at zero height");

  // Input backs up only when the output word is waiting on the sink
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output side could move");

endmodule

bind trot_gait_foot_trajectory_top tgft_checker u_tgft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for trot_gait_foot_trajectory_top: directed table, then random samples.
// Holds its own fixed-point model of the trot curves and checks every master word.
// Depends on tgft_pkg and the top module only.
`timescale 1ns / 1ps

module tb;
  import tgft_pkg::*;

  localparam int unsigned PhaseBits  = 16;
  localparam longint      OneQ       = longint'(1) << PhaseBits;
  localparam int unsigned RandCount  = 900;
  localparam int unsigned MaxIdle    = 11;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned HoldAfter  = 300;
  localparam int unsigned DrainWait  = 10;
  localparam longint      CycleLimit = 200000;

  // phase lowest, then stride, lift, dir_leg1..dir_leg4
  typedef struct packed {
    logic [NumLegs-1:0][DirW-1:0] dir;
    logic [AmpW-1:0]              lift;
    logic [AmpW-1:0]              stride;
    logic [PhaseW-1:0]            phase;
  } gait_sample_t;

  // x_leg1..x_leg4 lowest, then z_leg1..z_leg4
  typedef struct packed {
    logic [NumLegs-1:0][ZW-1:0] z;
    logic [NumLegs-1:0][XW-1:0] x;
  } foot_targets_t;

  typedef struct {
    gait_sample_t  smp;
    bit            typed;
    foot_targets_t want;
  } sample_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  foot_targets_t target_q[$];
  sample_row_t   plan[$];
  int unsigned   err_cnt     = 0;
  int unsigned   sent_cnt    = 0;
  int unsigned   checked_cnt = 0;
  int unsigned   taken_cnt   = 0;
  bit            held_off    = 1'b0;
  longint        cyc_cnt     = 0;

  trot_gait_foot_trajectory_top #(
    .PHASE_BITS(PhaseBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words still pending", cyc_cnt, target_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint clamp_unit(longint f);
    if (f < 0) return 0;
    if (f > OneQ) return OneQ;
    return f;
  endfunction

  // Foot targets of all four legs for one gait sample
  function automatic foot_targets_t trot_targets(gait_sample_t s);
    longint        u, u2, u3, fx, fz, fs, sw_x, sw_z, sp_x, amp_s, amp_l, xv;
    bit            second_half, swinging;
    foot_targets_t r;
    second_half = s.phase[PhaseBits-1];
    u  = longint'({s.phase[PhaseBits-2:0], 1'b0});
    u2 = (u * u) >>> PhaseBits;
    u3 = (u2 * u) >>> PhaseBits;
    if (u < OneQ / 4) fx = 0;
    else if (u < (3 * OneQ) / 4) fx = clamp_unit(-16 * u3 + 24 * u2 - 9 * u + OneQ);
    else fx = OneQ;
    if (u < OneQ / 2) fz = clamp_unit(-16 * u3 + 12 * u2);
    else fz = clamp_unit(-4 * u2 + 4 * u);
    fs = OneQ - u;
    amp_s = longint'($signed(s.stride));
    amp_l = longint'($signed(s.lift));
    sw_x = (amp_s * fx) >>> PhaseBits;
    sw_z = (amp_l * fz) >>> PhaseBits;
    sp_x = (amp_s * fs) >>> PhaseBits;
    for (int k = 0; k < NumLegs; k++) begin
      // legs 1 and 3 swing in the first half, legs 2 and 4 in the second
      swinging = ((k % 2) == 1) == second_half;
      xv = (swinging ? sw_x : sp_x) * longint'($signed(s.dir[k]));
      r.x[k] = XW'(xv);
      r.z[k] = swinging ? ZW'(sw_z) : '0;
    end
    return r;
  endfunction

  function automatic gait_sample_t mk_sample(int ph, int st, int lf, int d1, int d2, int d3,
                                             int d4);
    gait_sample_t s;
    s.phase  = PhaseW'(ph);
    s.stride = AmpW'(st);
    s.lift   = AmpW'(lf);
    s.dir[0] = DirW'(d1);
    s.dir[1] = DirW'(d2);
    s.dir[2] = DirW'(d3);
    s.dir[3] = DirW'(d4);
    return s;
  endfunction

  function automatic foot_targets_t mk_targets(int x1, int x2, int x3, int x4, int z1, int z2,
                                               int z3, int z4);
    foot_targets_t t;
    t.x[0] = XW'(x1); t.x[1] = XW'(x2); t.x[2] = XW'(x3); t.x[3] = XW'(x4);
    t.z[0] = ZW'(z1); t.z[1] = ZW'(z2); t.z[2] = ZW'(z3); t.z[3] = ZW'(z4);
    return t;
  endfunction

  // Random field value of width w, leaning toward the extremes now and then
  function automatic logic [15:0] biased_word(int unsigned w);
    logic [15:0] mask;
    mask = (16'(1) << w) - 16'(1);
    if ($urandom_range(99, 0) < 15) begin
      case ($urandom_range(4, 0))
        0: return 16'(1) << (w - 1);
        1: return (16'(1) << (w - 1)) - 16'(1);
        2: return '0;
        3: return mask;
        default: return 16'(1);
      endcase
    end
    return 16'($urandom) & mask;
  endfunction

  function automatic gait_sample_t random_sample();
    gait_sample_t s;
    // a quarter of the phases land near a curve segment boundary
    if ($urandom_range(3, 0) == 0)
      s.phase = PhaseW'(($urandom_range(7, 0) << 13) + $urandom_range(8, 0) - 4);
    else
      s.phase = PhaseW'($urandom);
    s.stride = biased_word(AmpW);
    s.lift   = biased_word(AmpW);
    for (int k = 0; k < NumLegs; k++) s.dir[k] = DirW'(biased_word(DirW));
    return s;
  endfunction

  task automatic offer(input gait_sample_t smp, input bit typed, input foot_targets_t want);
    int unsigned gap;
    gap = (((sent_cnt / 64) % 4) == 1) ? 0 : $urandom_range(MaxIdle, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    target_q.push_back(typed ? want : trot_targets(smp));
    sent_cnt++;
  endtask

  // Receiver: random stalls, idle-free stretches and one long hold-off
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (taken_cnt == HoldAfter && !held_off) begin
        held_off = 1'b1;
        stall = HoldCycles;
      end else begin
        stall = (((taken_cnt / 50) % 5) == 2) ? 0 : $urandom_range(MaxIdle, 0);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken_cnt++;
    end
  end

  always @(posedge clk_i) begin
    foot_targets_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (target_q.size() == 0) begin
        $error("result word 0x%h arrived with nothing pending", m_axis_tdata);
        err_cnt++;
      end else begin
        want = target_q.pop_front();
        for (int k = 0; k < NumLegs; k++) begin
          if (got.x[k] !== want.x[k]) begin
            $error("x_leg%0d expected %0d got %0d", k + 1, $signed(want.x[k]),
                   $signed(got.x[k]));
            err_cnt++;
          end
          if (got.z[k] !== want.z[k]) begin
            $error("z_leg%0d expected %0d got %0d", k + 1, $signed(want.z[k]),
                   $signed(got.z[k]));
            err_cnt++;
          end
        end
        checked_cnt++;
      end
    end
  end

  initial begin
    // phase zero: swing pair at rest, support pair at full stride
    plan.push_back('{mk_sample(16'h0000, 1000, 500, 1, 1, 1, 1), 1'b1,
                     mk_targets(0, 1000, 0, 1000, 0, 0, 0, 0)});
    // second half start with most negative stride and direction
    plan.push_back('{mk_sample(16'h8000, -32768, -32768, -128, -128, -128, -128), 1'b1,
                     mk_targets(4194304, 0, 4194304, 0, 0, 0, 0, 0)});
    // mid swing: half stride everywhere, swing pair at peak height
    plan.push_back('{mk_sample(16'h4000, 1000, 500, 1, 1, 1, 1), 1'b1,
                     mk_targets(500, 500, 500, 500, 500, 0, 500, 0)});
    plan.push_back('{mk_sample(16'hC000, 1000, 500, 1, 1, 1, 1), 1'b1,
                     mk_targets(500, 500, 500, 500, 0, 500, 0, 500)});
    plan.push_back('{mk_sample(16'hFFFF, 32767, 32767, 127, 127, 127, 127), 1'b0, '0});
    plan.push_back('{mk_sample(16'h7FFF, -32768, 32767, -128, 127, -128, 127), 1'b0, '0});
    plan.push_back('{mk_sample(16'h1FFF, 32767, -32768, 127, 127, 127, 127), 1'b0, '0});
    plan.push_back('{mk_sample(16'h2000, 32767, -32768, -1, -1, -1, -1), 1'b0, '0});
    plan.push_back('{mk_sample(16'h3FFF, -32768, -32768, -128, -128, -128, -128), 1'b0, '0});
    plan.push_back('{mk_sample(16'h5FFF, 32767, 32767, 127, 127, 127, 127), 1'b0, '0});
    plan.push_back('{mk_sample(16'h6000, 32767, 32767, -128, -128, -128, -128), 1'b0, '0});
    plan.push_back('{mk_sample(16'hA000, -32768, 32767, 127, -128, 0, 1), 1'b0, '0});
    plan.push_back('{mk_sample(16'hE000, -1, -1, -1, -1, -1, -1), 1'b0, '0});
    plan.push_back('{mk_sample(16'h0001, 32767, 32767, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_sample(16'hAAAA, -12345, 23456, 5, -6, 7, -8), 1'b0, '0});
    plan.push_back('{mk_sample(16'h5555, 0, 0, 127, 127, 127, 127), 1'b0, '0});
    // negative amplitudes round toward minus infinity
    plan.push_back('{mk_sample(16'h4000, -1, -1, 1, 1, 1, 1), 1'b0, '0});
    plan.push_back('{mk_sample(16'hDFFF, -32767, -32767, 127, -127, 127, -127), 1'b0, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) offer(plan[i].smp, plan[i].typed, plan[i].want);
    repeat (RandCount) offer(random_sample(), 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    while (target_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (target_q.size() != 0) begin
      $error("%0d expected words never arrived", target_q.size());
      err_cnt++;
    end

    $display("Sent %0d gait samples (%0d from the directed table), checked %0d words.",
             sent_cnt, plan.size(), checked_cnt);
    $display("Random idling on both sides plus one %0d-cycle receiver hold-off, %0d errors.",
             HoldCycles, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tgft_pkg.sv
rtl/core/tgft_factor.sv
rtl/core/trot_gait_foot_trajectory_top.sv
rtl/core/tgft_checker.sv
test/tb.sv
